>>> rtl/mcobm_pkg.sv
// Package for the multicart outer bank mapper: transaction kinds, register
// indexes, field widths, the outer register struct and the result struct.
// No dependencies.
`default_nettype none

package mcobm_pkg;

  localparam int unsigned KindW     = 3;
  localparam int unsigned PlaceW    = 3;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned PrgBankW  = 7;
  localparam int unsigned ChrBankW  = 10;
  localparam int unsigned DipW      = 4;

  // transaction kinds
  localparam logic [KindW-1:0] KIND_REG_WRITE  = 3'd0;
  localparam logic [KindW-1:0] KIND_ROM_READ   = 3'd1;
  localparam logic [KindW-1:0] KIND_PRG_XLATE  = 3'd2;
  localparam logic [KindW-1:0] KIND_CHR_XLATE  = 3'd3;
  localparam logic [KindW-1:0] KIND_SOFT_RESET = 3'd4;

  // outer register indexes (low two address bits)
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_BANK   = 2'd1;
  localparam logic [1:0] REG_CHR    = 2'd2;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [ByteW-1:0] mode;
    logic [ByteW-1:0] bank;
    logic [ByteW-1:0] chr;
  } outer_regs_t;

  typedef struct packed {
    logic [PrgBankW-1:0] prg_bank;
    logic [ChrBankW-1:0] chr_bank;
    logic [DipW-1:0]     read_data;
    logic                cart_read;
    logic                wram_write;
    logic                remap;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/mcobm_req_if.sv
// Request channel of the outer bank mapper: valid/ready plus request fields.
// Depends on mcobm_pkg.
`default_nettype none

interface mcobm_req_if;
  logic                          valid;
  logic                          ready;
  logic [mcobm_pkg::KindW-1:0]   kind;
  logic [mcobm_pkg::PlaceW-1:0]  place;
  logic [mcobm_pkg::ByteW-1:0]   value;
  logic [mcobm_pkg::ByteW-1:0]   bank_six;
  logic                          wram_writable;

  modport source (output valid, kind, place, value, bank_six, wram_writable, input ready);
  modport sink   (input valid, kind, place, value, bank_six, wram_writable, output ready);
endinterface

`default_nettype wire

>>> rtl/mcobm_rsp_if.sv
// Response channel of the outer bank mapper: valid/ready plus result fields.
// Depends on mcobm_pkg.
`default_nettype none

interface mcobm_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [mcobm_pkg::PrgBankW-1:0]  prg_bank;
  logic [mcobm_pkg::ChrBankW-1:0]  chr_bank;
  logic [mcobm_pkg::DipW-1:0]      read_data;
  logic                            cart_read;
  logic                            wram_write;
  logic                            remap;

  modport source (output valid, prg_bank, chr_bank, read_data, cart_read, wram_write, remap,
                  input ready);
  modport sink   (input valid, prg_bank, chr_bank, read_data, cart_read, wram_write, remap,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/multicart_outer_bank_mapper.sv
// Top level of the multicart outer bank mapper: input stage, outer register
// update and result register. Depends on mcobm_pkg, mcobm_req_if,
// mcobm_rsp_if and mcobm_xlate.
//
//   channel  dir  payload                                              flow
//   req_i    in   kind place value bank_six wram_writable              valid/ready
//   rsp_o    out  prg_bank chr_bank read_data cart_read wram_write remap valid/ready
//
// Two register stages: a request is captured in the input stage, then the
// translation and register update feed the result register combinationally.
// Throughput is one transaction per cycle while rsp_o takes each result.
// Reset clears the outer registers, the DIP value and both stage valids.
// A stalled result holds in place; the stages ahead keep filling until full.
`default_nettype none

module multicart_outer_bank_mapper (
  input  wire         clk_i,
  input  wire         rst_ni,
  mcobm_req_if.sink   req_i,
  mcobm_rsp_if.source rsp_o
);

  // input stage
  logic                          s1_valid_q;
  logic [mcobm_pkg::KindW-1:0]   s1_kind_q;
  logic [mcobm_pkg::PlaceW-1:0]  s1_place_q;
  logic [mcobm_pkg::ByteW-1:0]   s1_value_q;
  logic [mcobm_pkg::ByteW-1:0]   s1_bank_six_q;
  logic                          s1_writable_q;
  logic                          s1_ready;
  logic                          s1_fire;

  // state
  mcobm_pkg::outer_regs_t        regs_q, regs_d;
  logic [mcobm_pkg::DipW-1:0]    dip_q, dip_d;

  // result stage
  logic                          out_valid_q;
  mcobm_pkg::result_t            res_q, res_d;

  logic [mcobm_pkg::PrgBankW-1:0] prg_bank;
  logic [mcobm_pkg::ChrBankW-1:0] chr_bank;

  assign s1_ready    = !out_valid_q || rsp_o.ready;
  assign s1_fire     = s1_valid_q && s1_ready;
  assign req_i.ready = !s1_valid_q || s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_kind_q     <= req_i.kind;
      s1_place_q    <= req_i.place;
      s1_value_q    <= req_i.value;
      s1_bank_six_q <= req_i.bank_six;
      s1_writable_q <= req_i.wram_writable;
    end
  end

  mcobm_xlate u_xlate (
    .regs_i     (regs_q),
    .place_i    (s1_place_q),
    .value_i    (s1_value_q),
    .bank_six_i (s1_bank_six_q),
    .prg_bank_o (prg_bank),
    .chr_bank_o (chr_bank)
  );

  always_comb begin
    regs_d = regs_q;
    dip_d  = dip_q;
    res_d  = '0;
    unique case (s1_kind_q)
      mcobm_pkg::KIND_REG_WRITE: begin
        if (s1_writable_q) begin
          res_d.wram_write = 1'b1;
          if (!regs_q.mode[7]) begin
            res_d.remap = 1'b1;
            unique case (s1_place_q[1:0])
              mcobm_pkg::REG_MODE:   regs_d.mode = s1_value_q;
              mcobm_pkg::REG_BANK:   regs_d.bank = s1_value_q;
              mcobm_pkg::REG_CHR:    regs_d.chr  = s1_value_q;
              mcobm_pkg::REG_UNUSED: ;
              default: ;
            endcase
          end else if (s1_place_q[1:0] == mcobm_pkg::REG_CHR) begin
            // locked: only the low two bits of the CHR outer reg stay writable
            res_d.remap      = 1'b1;
            regs_d.chr[1:0]  = s1_value_q[1:0];
          end
        end
      end
      mcobm_pkg::KIND_ROM_READ: begin
        if (regs_q.mode[6]) begin
          res_d.read_data = dip_q;
        end else begin
          res_d.cart_read = 1'b1;
        end
      end
      mcobm_pkg::KIND_PRG_XLATE: res_d.prg_bank = prg_bank;
      mcobm_pkg::KIND_CHR_XLATE: res_d.chr_bank = chr_bank;
      mcobm_pkg::KIND_SOFT_RESET: begin
        dip_d       = dip_q + mcobm_pkg::DipW'(1);
        regs_d      = '0;
        res_d.remap = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q      <= '0;
      dip_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_fire) begin
        regs_q <= regs_d;
        dip_q  <= dip_d;
      end
      if (s1_ready) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_q <= res_d;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.prg_bank   = res_q.prg_bank;
  assign rsp_o.chr_bank   = res_q.chr_bank;
  assign rsp_o.read_data  = res_q.read_data;
  assign rsp_o.cart_read  = res_q.cart_read;
  assign rsp_o.wram_write = res_q.wram_write;
  assign rsp_o.remap      = res_q.remap;

  // lock bit only drops through a soft reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    regs_q.mode[7] && !(s1_fire && s1_kind_q == mcobm_pkg::KIND_SOFT_RESET)
    |=> regs_q.mode[7])
    else $error("outer lock released without soft reset");

  // DIP value moves only on a soft reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_fire && s1_kind_q == mcobm_pkg::KIND_SOFT_RESET) |=> $stable(dip_q))
    else $error("DIP value changed outside soft reset");

  // a ROM read result is either DIP data or cartridge data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.cart_read |-> res_q.read_data == '0 && !res_q.remap)
    else $error("cartridge read mixed with DIP data");

  // state only changes when a transaction moves into the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(regs_q))
    else $error("outer registers changed without a transaction");

endmodule

`default_nettype wire

>>> rtl/mcobm_xlate.sv
// PRG and CHR bank translation from inner MMC3 bank numbers and outer regs.
// Pure combinational; depends on mcobm_pkg.
`default_nettype none

module mcobm_xlate (
  input  var mcobm_pkg::outer_regs_t          regs_i,
  input  wire [mcobm_pkg::PlaceW-1:0]         place_i,
  input  wire [mcobm_pkg::ByteW-1:0]          value_i,
  input  wire [mcobm_pkg::ByteW-1:0]          bank_six_i,
  output logic [mcobm_pkg::PrgBankW-1:0]      prg_bank_o,
  output logic [mcobm_pkg::ChrBankW-1:0]      chr_bank_o
);

  logic [mcobm_pkg::PrgBankW-1:0] prg_mask;
  logic [mcobm_pkg::PrgBankW-1:0] prg_hi;
  logic [mcobm_pkg::PrgBankW-1:0] prg_sel;
  logic [mcobm_pkg::ByteW-1:0]    sel_b6;

  logic [mcobm_pkg::ByteW-1:0]    chr_mask;
  logic [mcobm_pkg::ChrBankW-1:0] chr_hi;
  logic [6:0]                     chr_b8;

  // PRG: 128K or 256K outer window, NROM modes take the bank from MMC3 reg 6
  always_comb begin
    prg_mask = regs_i.bank[2] ? 7'h0F : 7'h1F;
    prg_hi   = {regs_i.mode[4], regs_i.bank[1:0], 4'h0} & ~prg_mask;
    if (regs_i.bank[3]) begin
      sel_b6 = bank_six_i;
    end else if (!place_i[1]) begin
      sel_b6 = bank_six_i & ~8'h02;
    end else begin
      sel_b6 = bank_six_i | 8'h02;
    end
    prg_sel = sel_b6[mcobm_pkg::PrgBankW-1:0] & prg_mask;
    if (regs_i.bank[7]) begin
      prg_bank_o = prg_hi | {prg_sel[6:1], place_i[0]};
    end else begin
      prg_bank_o = prg_hi | (value_i[mcobm_pkg::PrgBankW-1:0] & prg_mask);
    end
  end

  // CHR: 128K or 256K outer window, CNROM mode builds the 1K bank from chr_outer
  always_comb begin
    chr_mask = regs_i.bank[6] ? 8'h7F : 8'hFF;
    chr_hi   = {regs_i.mode[5], regs_i.bank[5:4], 7'h00} & ~{2'b00, chr_mask};
    chr_b8   = chr_hi[9:3] | {2'b00, regs_i.chr[4:0] & chr_mask[7:3]};
    if (regs_i.mode[3]) begin
      chr_bank_o = {chr_b8, place_i};
    end else begin
      chr_bank_o = chr_hi | {2'b00, value_i & chr_mask};
    end
  end

endmodule

`default_nettype wire

>>> bench/tb_multicart_outer_bank_mapper.sv
`timescale 1ns / 1ps
// Self-checking bench for multicart_outer_bank_mapper: directed and random requests,
// with results checked against an in-bench model of the outer registers.
// Depends on mcobm_pkg, mcobm_req_if, mcobm_rsp_if and the mapper RTL.

module tb_multicart_outer_bank_mapper;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned HoldCycles = 60;

  typedef struct packed {
    logic [mcobm_pkg::KindW-1:0]  kind;
    logic [mcobm_pkg::PlaceW-1:0] place;
    logic [mcobm_pkg::ByteW-1:0]  value;
    logic [mcobm_pkg::ByteW-1:0]  bank_six;
    logic                         wram_writable;
  } mapper_req_t;

  logic clk = 1'b0;
  logic rst_n;

  mcobm_req_if req_if ();
  mcobm_rsp_if rsp_if ();

  multicart_outer_bank_mapper dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  mapper_req_t          pending_reqs[$];
  mcobm_pkg::result_t   expected_results[$];
  int unsigned total_reqs;
  int unsigned sent_cnt;
  int unsigned idle_phase;
  int unsigned send_idle;
  int unsigned recv_idle;
  int unsigned hold_cnt;
  logic        hold_done;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt;

  // shadow of the block's outer registers and DIP counter
  logic [mcobm_pkg::ByteW-1:0] mdl_mode = '0;
  logic [mcobm_pkg::ByteW-1:0] mdl_bank = '0;
  logic [mcobm_pkg::ByteW-1:0] mdl_chr  = '0;
  logic [mcobm_pkg::DipW-1:0]  mdl_dip  = '0;

  assign send_idle = (idle_phase == 0) ? 36 : (idle_phase == 1) ? 84 : 0;
  assign recv_idle = (idle_phase == 0) ? 84 : (idle_phase == 1) ? 36 : 0;

  function automatic mcobm_pkg::result_t predict_mapping(input mapper_req_t rq);
    mcobm_pkg::result_t                res;
    logic [mcobm_pkg::PrgBankW-1:0]    pmask;
    logic [mcobm_pkg::PrgBankW-1:0]    phi;
    logic [mcobm_pkg::ByteW-1:0]       sel;
    logic [1:0]                        pslot;
    logic [mcobm_pkg::ChrBankW-1:0]    cmask;
    logic [mcobm_pkg::ChrBankW-1:0]    chi;
    logic [mcobm_pkg::ChrBankW-1:0]    b8;
    res = '0;
    case (rq.kind)
      mcobm_pkg::KIND_REG_WRITE: begin
        if (rq.wram_writable) begin
          res.wram_write = 1'b1;
          if (!mdl_mode[7]) begin
            case (rq.place[1:0])
              mcobm_pkg::REG_MODE: mdl_mode = rq.value;
              mcobm_pkg::REG_BANK: mdl_bank = rq.value;
              mcobm_pkg::REG_CHR:  mdl_chr  = rq.value;
              default: ;
            endcase
            res.remap = 1'b1;
          end else if (rq.place[1:0] == mcobm_pkg::REG_CHR) begin
            // locked: only the low two CHR bits still take writes
            mdl_chr[1:0] = rq.value[1:0];
            res.remap = 1'b1;
          end
        end
      end
      mcobm_pkg::KIND_ROM_READ: begin
        if (mdl_mode[6]) res.read_data = mdl_dip;
        else res.cart_read = 1'b1;
      end
      mcobm_pkg::KIND_PRG_XLATE: begin
        pmask = mdl_bank[2] ? 7'h0F : 7'h1F;
        phi   = {mdl_mode[4], mdl_bank[1:0], 4'b0000} & ~pmask;
        pslot = rq.place[1:0];
        if (mdl_bank[7]) begin
          // NROM modes: bank comes from register 6, slot picks the 8K half
          if (mdl_bank[3]) sel = rq.bank_six;
          else if (pslot < 2) sel = rq.bank_six & 8'hFD;
          else sel = rq.bank_six | 8'h02;
          res.prg_bank = phi | ((sel[mcobm_pkg::PrgBankW-1:0] & pmask) & 7'h7E)
                         | {6'b0, pslot[0]};
        end else begin
          res.prg_bank = phi | (rq.value[mcobm_pkg::PrgBankW-1:0] & pmask);
        end
      end
      mcobm_pkg::KIND_CHR_XLATE: begin
        cmask = mdl_bank[6] ? 10'h07F : 10'h0FF;
        chi   = {mdl_mode[5], mdl_bank[5:4], 7'b0} & ~cmask;
        if (mdl_mode[3]) begin
          b8 = (chi >> 3) | ({2'b00, mdl_chr} & (cmask >> 3));
          res.chr_bank = (b8 << 3) | {7'b0, rq.place};
        end else begin
          res.chr_bank = chi | ({2'b00, rq.value} & cmask);
        end
      end
      mcobm_pkg::KIND_SOFT_RESET: begin
        mdl_dip  = mdl_dip + mcobm_pkg::DipW'(1);
        mdl_mode = '0;
        mdl_bank = '0;
        mdl_chr  = '0;
        res.remap = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic queue_req(input logic [mcobm_pkg::KindW-1:0] kind, input int unsigned place,
                           input int unsigned value, input int unsigned b6,
                           input logic wr);
    mapper_req_t rq;
    rq.kind          = kind;
    rq.place         = place[mcobm_pkg::PlaceW-1:0];
    rq.value         = value[mcobm_pkg::ByteW-1:0];
    rq.bank_six      = b6[mcobm_pkg::ByteW-1:0];
    rq.wram_writable = wr;
    pending_reqs.push_back(rq);
  endtask

  function automatic mapper_req_t random_req();
    mapper_req_t rq;
    int unsigned r;
    r = $urandom_range(99);
    rq.place         = mcobm_pkg::PlaceW'($urandom_range(7));
    rq.value         = mcobm_pkg::ByteW'($urandom_range(255));
    rq.bank_six      = mcobm_pkg::ByteW'($urandom_range(255));
    rq.wram_writable = 1'($urandom_range(1));
    if (r < 28) begin
      rq.kind = mcobm_pkg::KIND_REG_WRITE;
      rq.wram_writable = ($urandom_range(9) != 0);
      // keep the lock bit rare so most writes reach the registers
      if (rq.place[1:0] == mcobm_pkg::REG_MODE && $urandom_range(9) != 0) rq.value[7] = 1'b0;
    end else if (r < 38) begin
      rq.kind = mcobm_pkg::KIND_ROM_READ;
    end else if (r < 62) begin
      rq.kind = mcobm_pkg::KIND_PRG_XLATE;
    end else if (r < 86) begin
      rq.kind = mcobm_pkg::KIND_CHR_XLATE;
    end else if (r < 92) begin
      rq.kind = mcobm_pkg::KIND_SOFT_RESET;
    end else begin
      rq.kind = mcobm_pkg::KindW'($urandom_range(7, 5));
    end
    return rq;
  endfunction

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;

    // directed part
    queue_req(mcobm_pkg::KIND_ROM_READ, 0, 8'h00, 8'h00, 1'b0);
    // refused, RAM not writable
    queue_req(mcobm_pkg::KIND_REG_WRITE, mcobm_pkg::REG_MODE, 8'hFF, 8'hFF, 1'b0);
    queue_req(mcobm_pkg::KIND_REG_WRITE, mcobm_pkg::REG_UNUSED, 8'hAA, 8'h00, 1'b1);
    queue_req(mcobm_pkg::KIND_REG_WRITE, mcobm_pkg::REG_BANK, 8'h00, 8'h00, 1'b1);
    queue_req(mcobm_pkg::KIND_PRG_XLATE, 2, 8'hFF, 8'h00, 1'b0);
    queue_req(mcobm_pkg::KIND_PRG_XLATE, 7, 8'hFF, 8'hFF, 1'b1);          // slot wraps
    queue_req(mcobm_pkg::KIND_REG_WRITE, mcobm_pkg::REG_MODE, 8'h40, 8'h00, 1'b1);
    queue_req(mcobm_pkg::KIND_ROM_READ, 0, 8'h00, 8'h00, 1'b0);
    queue_req(mcobm_pkg::KIND_SOFT_RESET, 0, 8'h00, 8'h00, 1'b0);
    queue_req(mcobm_pkg::KIND_ROM_READ, 0, 8'h00, 8'h00, 1'b0);
    queue_req(mcobm_pkg::KIND_REG_WRITE, mcobm_pkg::REG_MODE, 8'h40, 8'h00, 1'b1);
    queue_req(mcobm_pkg::KIND_ROM_READ, 7, 8'hFF, 8'hFF, 1'b1);
    queue_req(mcobm_pkg::KIND_REG_WRITE, mcobm_pkg::REG_BANK, 8'h87, 8'h00, 1'b1); // NROM-256
    queue_req(mcobm_pkg::KIND_PRG_XLATE, 0, 8'h00, 8'hFF, 1'b0);
    queue_req(mcobm_pkg::KIND_PRG_XLATE, 3, 8'h00, 8'hFF, 1'b0);
    queue_req(mcobm_pkg::KIND_REG_WRITE, mcobm_pkg::REG_BANK, 8'h8F, 8'h00, 1'b1); // NROM-128
    queue_req(mcobm_pkg::KIND_PRG_XLATE, 1, 8'h00, 8'h55, 1'b0);
    queue_req(mcobm_pkg::KIND_REG_WRITE, mcobm_pkg::REG_BANK, 8'h70, 8'h00, 1'b1);
    queue_req(mcobm_pkg::KIND_REG_WRITE, mcobm_pkg::REG_CHR, 8'hFF, 8'h00, 1'b1);
    // CNROM, locked
    queue_req(mcobm_pkg::KIND_REG_WRITE, mcobm_pkg::REG_MODE, 8'hB8, 8'h00, 1'b1);
    queue_req(mcobm_pkg::KIND_CHR_XLATE, 7, 8'hAA, 8'h00, 1'b0);
    // dropped while locked
    queue_req(mcobm_pkg::KIND_REG_WRITE, mcobm_pkg::REG_BANK, 8'h00, 8'h00, 1'b1);
    queue_req(mcobm_pkg::KIND_REG_WRITE, mcobm_pkg::REG_CHR, 8'h02, 8'h00, 1'b1);
    queue_req(mcobm_pkg::KIND_CHR_XLATE, 0, 8'hFF, 8'hFF, 1'b1);
    queue_req(mcobm_pkg::KIND_SOFT_RESET + 3'd3, 7, 8'hFF, 8'hFF, 1'b1);  // unused kind
    queue_req(mcobm_pkg::KIND_SOFT_RESET, 0, 8'h00, 8'h00, 1'b0);

    repeat (1900) pending_reqs.push_back(random_req());
    total_reqs = pending_reqs.size();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    do @(negedge clk);
    while (pending_reqs.size() != 0 || req_if.valid || expected_results.size() != 0);
    repeat (8) @(posedge clk);
    if (err_cnt == 0) $display("tb_multicart_outer_bank_mapper OK");
    else $display("tb_multicart_outer_bank_mapper NOT OK");
    $finish;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb_multicart_outer_bank_mapper NOT OK");
    $finish;
  end

  // driver: predicts on each accepted transaction, then offers the next request
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_if.valid         <= 1'b0;
      req_if.kind          <= '0;
      req_if.place         <= '0;
      req_if.value         <= '0;
      req_if.bank_six      <= '0;
      req_if.wram_writable <= 1'b0;
      sent_cnt             <= 0;
      idle_phase           <= 0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_results.push_back(predict_mapping('{req_if.kind, req_if.place, req_if.value,
                                                     req_if.bank_six, req_if.wram_writable}));
      end
      idle_phase <= (sent_cnt < total_reqs / 3) ? 0 : (sent_cnt < 2 * total_reqs / 3) ? 1 : 2;
      if (req_if.valid && !req_if.ready) begin
        // hold the current transaction
      end else if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle) begin
        req_if.kind          <= pending_reqs[0].kind;
        req_if.place         <= pending_reqs[0].place;
        req_if.value         <= pending_reqs[0].value;
        req_if.bank_six      <= pending_reqs[0].bank_six;
        req_if.wram_writable <= pending_reqs[0].wram_writable;
        req_if.valid         <= 1'b1;
        void'(pending_reqs.pop_front());
        sent_cnt <= sent_cnt + 1;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // receiver ready, with one long hold-off once idling stops
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
      hold_cnt     <= 0;
      hold_done    <= 1'b0;
    end else if (hold_cnt != 0) begin
      rsp_if.ready <= 1'b0;
      hold_cnt     <= hold_cnt - 1;
    end else if (!hold_done && idle_phase == 2) begin
      rsp_if.ready <= 1'b0;
      hold_cnt     <= HoldCycles;
      hold_done    <= 1'b1;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with nothing expected");
        err_cnt++;
      end else begin
        if (rsp_if.prg_bank !== expected_results[0].prg_bank) begin
          $error("prg_bank: expected %0d, got %0d", expected_results[0].prg_bank,
                 rsp_if.prg_bank);
          err_cnt++;
        end
        if (rsp_if.chr_bank !== expected_results[0].chr_bank) begin
          $error("chr_bank: expected %0d, got %0d", expected_results[0].chr_bank,
                 rsp_if.chr_bank);
          err_cnt++;
        end
        if (rsp_if.read_data !== expected_results[0].read_data) begin
          $error("read_data: expected %0d, got %0d", expected_results[0].read_data,
                 rsp_if.read_data);
          err_cnt++;
        end
        if (rsp_if.cart_read !== expected_results[0].cart_read) begin
          $error("cart_read: expected %0d, got %0d", expected_results[0].cart_read,
                 rsp_if.cart_read);
          err_cnt++;
        end
        if (rsp_if.wram_write !== expected_results[0].wram_write) begin
          $error("wram_write: expected %0d, got %0d", expected_results[0].wram_write,
                 rsp_if.wram_write);
          err_cnt++;
        end
        if (rsp_if.remap !== expected_results[0].remap) begin
          $error("remap: expected %0d, got %0d", expected_results[0].remap, rsp_if.remap);
          err_cnt++;
        end
        void'(expected_results.pop_front());
      end
    end
  end

endmodule
